### rtl/core/bse_pkg.sv
package bse_pkg;

	localparam int unsigned FC_W     = 22;
	localparam int unsigned SOC_W    = 10;
	localparam int unsigned DIV_W    = 48;
	localparam int unsigned CNT_W    = 32;

	localparam logic [SOC_W-1:0] SOC_MAX = 10'd1000;

	localparam logic [2:0] REG_FULL_CAPACITY  = 3'd0;
	localparam logic [2:0] REG_START_SOC      = 3'd1;
	localparam logic [2:0] REG_BLEND_STEP     = 3'd2;
	localparam logic [2:0] REG_IDLE_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_IDLE_DELAY     = 3'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_REINIT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_WINIT,
		ST_SAMP,
		ST_WACC,
		ST_EST,
		ST_WEST,
		ST_CORR,
		ST_WCHG,
		ST_OUT
	} state_t;

endpackage

### rtl/core/bse_div.sv
module bse_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bse_pkg::DIV_W-1:0]         dividend,
	input  logic [bse_pkg::FC_W-1:0]          divisor,
	output logic                              done,
	output logic [bse_pkg::DIV_W-1:0]         quotient
);

	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [bse_pkg::FC_W-1:0]     rem_q;
	logic [bse_pkg::DIV_W-1:0]    quo_q;
	logic [bse_pkg::FC_W:0]       trial;
	logic                         fits;

	assign trial = {rem_q, quo_q[bse_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(bse_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? bse_pkg::FC_W'(trial - {1'b0, divisor})
			              : trial[bse_pkg::FC_W-1:0];
			quo_q <= {quo_q[bse_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/battery_soc_estimator_top.sv
// channel | valid     | stall      | payload
// in      | in_valid  | in_stall   | op, tick_time_ms, charge_ma, discharge_ma, ocv_soc
// out     | out_valid | out_stall  | est_soc_out ... corrections_total
// cfg     | cfg_we    | -          | cfg_index, cfg_data
// Work per word: up to three divisions for a sample, one for a reinit.
// Each division runs on the one shared restoring divider: a start strobe, 48 bit steps and a
// done strobe; after each result the FSM returns to idle before the next word is taken.
// Reset loads the register defaults and the matching start state.
// A finished word waits in the output register; a new word is taken meanwhile.
module battery_soc_estimator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [21:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [31:0]                     tick_time_ms,
	input  logic [14:0]                     charge_ma,
	input  logic [14:0]                     discharge_ma,
	input  logic [15:0]                     ocv_soc,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [9:0]                      est_soc_out,
	output logic [15:0]                     ocv_soc_out,
	output logic signed [16:0]              soc_error,
	output logic                            flag_charge,
	output logic                            flag_discharge,
	output logic                            flag_clamped_empty,
	output logic                            flag_clamped_full,
	output logic                            flag_ocv_corrected,
	output logic [31:0]                     empty_clamps_total,
	output logic [31:0]                     full_clamps_total,
	output logic [31:0]                     corrections_total
);

	localparam int unsigned DW = bse_pkg::DIV_W;

	bse_pkg::state_t state_q, state_nx;

	logic [21:0] fc_q;
	logic [9:0]  start_soc_q, blend_q;
	logic [15:0] idle_thr_q;
	logic [7:0]  idle_dly_q;

	logic        op_q;
	logic [31:0] tick_q;
	logic [14:0] chg_q, dis_q;
	logic [15:0] ocv_q;

	logic [21:0] rem_q;
	logic [9:0]  est_q;
	logic [31:0] last_q;
	logic        tvalid_q;
	logic [7:0]  idle_q;
	logic [31:0] emp_cnt_q, full_cnt_q, corr_cnt_q;
	logic        f_chg_q, f_dis_q, f_emp_q, f_full_q, f_corr_q;
	logic        neg_q;

	logic        out_valid_q;
	logic        in_acc, out_acc;

	logic        div_start;
	logic [DW-1:0] div_dividend;
	logic [21:0] div_divisor;
	logic        div_done;
	logic [DW-1:0] div_q;

	logic signed [15:0] net;
	logic [15:0] absn;
	logic [31:0] delta;
	logic [9:0]  init_soc;
	logic signed [DW+1:0] acc_next;
	logic        corr_ok;
	logic [9:0]  diff, step, est_corr;
	logic        free_out;

	bse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign free_out = !out_valid_q || !out_stall;

	assign net      = $signed({1'b0, chg_q}) - $signed({1'b0, dis_q});
	assign absn     = net[15] ? 16'(-net) : net;
	assign delta    = (tvalid_q && tick_q > last_q) ? tick_q - last_q : 32'd0;
	assign init_soc = (start_soc_q > bse_pkg::SOC_MAX) ? bse_pkg::SOC_MAX : start_soc_q;
	assign acc_next = neg_q ? $signed({28'd0, rem_q}) - $signed({2'b00, div_q})
	                        : $signed({28'd0, rem_q}) + $signed({2'b00, div_q});

	assign corr_ok  = ocv_q <= 16'd1000 && idle_q >= idle_dly_q && ocv_q != {6'd0, est_q};
	assign diff     = (ocv_q[9:0] > est_q) ? ocv_q[9:0] - est_q : est_q - ocv_q[9:0];
	assign step     = (blend_q < diff) ? blend_q : diff;
	assign est_corr = (ocv_q[9:0] > est_q) ? est_q + step : est_q - step;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			bse_pkg::ST_IDLE: if (in_acc) state_nx = (op == bse_pkg::OP_REINIT)
			                                        ? bse_pkg::ST_INIT : bse_pkg::ST_SAMP;
			bse_pkg::ST_INIT: state_nx = bse_pkg::ST_WINIT;
			bse_pkg::ST_WINIT: if (div_done) state_nx = bse_pkg::ST_OUT;
			bse_pkg::ST_SAMP: state_nx = (delta != 32'd0) ? bse_pkg::ST_WACC
			                                             : bse_pkg::ST_EST;
			bse_pkg::ST_WACC: if (div_done) state_nx = bse_pkg::ST_EST;
			bse_pkg::ST_EST: state_nx = (fc_q == 22'd0) ? bse_pkg::ST_CORR
			                                            : bse_pkg::ST_WEST;
			bse_pkg::ST_WEST: if (div_done) state_nx = bse_pkg::ST_CORR;
			bse_pkg::ST_CORR: state_nx = corr_ok ? bse_pkg::ST_WCHG : bse_pkg::ST_OUT;
			bse_pkg::ST_WCHG: if (div_done) state_nx = bse_pkg::ST_OUT;
			bse_pkg::ST_OUT: if (free_out) state_nx = bse_pkg::ST_IDLE;
			default: state_nx = bse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = 22'd1000;
		case (state_q)
			bse_pkg::ST_IDLE: in_stall = 1'b0;
			bse_pkg::ST_INIT: begin
				div_start    = 1'b1;
				div_dividend = DW'(fc_q * init_soc);
			end
			bse_pkg::ST_WINIT, bse_pkg::ST_WCHG: div_divisor = 22'd1000;
			bse_pkg::ST_WACC: div_divisor = 22'd100;
			bse_pkg::ST_EST: begin
				div_start    = (fc_q != 22'd0);
				div_dividend = DW'(rem_q * 10'd1000);
				div_divisor  = fc_q;
			end
			bse_pkg::ST_WEST: div_divisor = fc_q;
			bse_pkg::ST_CORR: begin
				div_start    = corr_ok;
				div_dividend = DW'(fc_q * est_corr);
			end
			default: in_stall = 1'b1;
		endcase
		if (state_q == bse_pkg::ST_SAMP) begin
			div_start    = (delta != 32'd0);
			div_dividend = DW'(absn * delta);
			div_divisor  = 22'd100;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bse_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			fc_q        <= 22'd2160000;
			start_soc_q <= 10'd800;
			blend_q     <= 10'd15;
			idle_thr_q  <= 16'd150;
			idle_dly_q  <= 8'd3;
			rem_q       <= 22'd1728000;
			est_q       <= 10'd800;
			last_q      <= '0;
			tvalid_q    <= 1'b0;
			idle_q      <= '0;
			emp_cnt_q   <= '0;
			full_cnt_q  <= '0;
			corr_cnt_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					bse_pkg::REG_FULL_CAPACITY:  fc_q        <= cfg_data;
					bse_pkg::REG_START_SOC:      start_soc_q <= cfg_data[9:0];
					bse_pkg::REG_BLEND_STEP:     blend_q     <= cfg_data[9:0];
					bse_pkg::REG_IDLE_THRESHOLD: idle_thr_q  <= cfg_data[15:0];
					bse_pkg::REG_IDLE_DELAY:     idle_dly_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (state_q == bse_pkg::ST_OUT && free_out) out_valid_q <= 1'b1;
			else if (out_acc) out_valid_q <= 1'b0;
			case (state_q)
				bse_pkg::ST_INIT: begin
					est_q      <= init_soc;
					last_q     <= '0;
					tvalid_q   <= 1'b0;
					idle_q     <= '0;
					emp_cnt_q  <= '0;
					full_cnt_q <= '0;
					corr_cnt_q <= '0;
				end
				bse_pkg::ST_WINIT, bse_pkg::ST_WCHG: if (div_done)
					rem_q <= (div_q > {26'd0, fc_q}) ? fc_q : div_q[21:0];
				bse_pkg::ST_SAMP: begin
					last_q   <= tick_q;
					tvalid_q <= 1'b1;
					if (absn <= idle_thr_q) begin
						if (idle_q != 8'hFF) idle_q <= idle_q + 8'd1;
					end else begin
						idle_q <= '0;
					end
				end
				bse_pkg::ST_WACC: if (div_done) begin
					if (acc_next < 0) begin
						rem_q     <= '0;
						emp_cnt_q <= emp_cnt_q + 32'd1;
					end else if (acc_next > $signed({28'd0, fc_q})) begin
						rem_q      <= fc_q;
						full_cnt_q <= full_cnt_q + 32'd1;
					end else begin
						rem_q <= acc_next[21:0];
					end
				end
				bse_pkg::ST_EST: if (fc_q == 22'd0) est_q <= '0;
				bse_pkg::ST_WEST: if (div_done)
					est_q <= (div_q > DW'(bse_pkg::SOC_MAX)) ? bse_pkg::SOC_MAX : div_q[9:0];
				bse_pkg::ST_CORR: if (corr_ok) begin
					est_q      <= est_corr;
					corr_cnt_q <= corr_cnt_q + 32'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op;
			tick_q <= tick_time_ms;
			chg_q  <= charge_ma;
			dis_q  <= discharge_ma;
			ocv_q  <= ocv_soc;
		end
		case (state_q)
			bse_pkg::ST_INIT: begin
				f_chg_q  <= 1'b0;
				f_dis_q  <= 1'b0;
				f_emp_q  <= 1'b0;
				f_full_q <= 1'b0;
				f_corr_q <= 1'b0;
			end
			bse_pkg::ST_SAMP: begin
				f_chg_q  <= !net[15] && net != 16'sd0;
				f_dis_q  <= net[15];
				f_emp_q  <= 1'b0;
				f_full_q <= 1'b0;
				f_corr_q <= 1'b0;
				neg_q    <= net[15];
			end
			bse_pkg::ST_WACC: if (div_done) begin
				f_emp_q  <= acc_next < 0;
				f_full_q <= acc_next > $signed({28'd0, fc_q});
			end
			bse_pkg::ST_CORR: f_corr_q <= corr_ok;
			bse_pkg::ST_OUT: if (free_out) begin
				est_soc_out        <= est_q;
				ocv_soc_out        <= ocv_q;
				soc_error          <= $signed({7'd0, est_q}) - $signed({1'b0, ocv_q});
				flag_charge        <= f_chg_q && (op_q == bse_pkg::OP_SAMPLE);
				flag_discharge     <= f_dis_q;
				flag_clamped_empty <= f_emp_q;
				flag_clamped_full  <= f_full_q;
				flag_ocv_corrected <= f_corr_q;
				empty_clamps_total <= emp_cnt_q;
				full_clamps_total  <= full_cnt_q;
				corrections_total  <= corr_cnt_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

typedef struct {
	logic [9:0]  est;
	logic [15:0] ocv;
	logic [16:0] err;
	logic        chg, dis, emp, full, corr;
	logic [31:0] n_emp, n_full, n_corr;
} soc_word_t;

class soc_scoreboard;
	logic [21:0] capacity;
	logic [9:0]  start_level;
	logic [9:0]  step_limit;
	logic [15:0] idle_limit;
	logic [7:0]  idle_needed;
	logic [21:0] charge_left;
	logic [9:0]  level;
	logic [31:0] prev_tick;
	bit          tick_seen;
	logic [7:0]  idle_run;
	logic [31:0] cnt_emp, cnt_full, cnt_corr;
	soc_word_t   pending[$];
	int          errors;

	function new();
		capacity = 22'd2160000;
		start_level = 10'd800;
		step_limit = 10'd15;
		idle_limit = 16'd150;
		idle_needed = 8'd3;
		errors = 0;
		reload();
	endfunction

	function logic [21:0] charge_of(longint unsigned s);
		longint unsigned r;
		r = (longint'(capacity) * s) / 1000;
		if (r > capacity)
			r = capacity;
		return r[21:0];
	endfunction

	function void reload();
		longint unsigned s;
		s = start_level > 1000 ? 1000 : start_level;
		charge_left = charge_of(s);
		level = s[9:0];
		prev_tick = '0;
		tick_seen = 0;
		idle_run = '0;
		cnt_emp = '0;
		cnt_full = '0;
		cnt_corr = '0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [21:0] v);
		case (idx)
			bse_pkg::REG_FULL_CAPACITY: capacity = v;
			bse_pkg::REG_START_SOC: start_level = v[9:0];
			bse_pkg::REG_BLEND_STEP: step_limit = v[9:0];
			bse_pkg::REG_IDLE_THRESHOLD: idle_limit = v[15:0];
			bse_pkg::REG_IDLE_DELAY: idle_needed = v[7:0];
			default: ;
		endcase
	endfunction

	function void note_input(logic o, logic [31:0] tick, logic [14:0] c,
			logic [14:0] d, logic [15:0] ocv);
		soc_word_t w;
		longint nt, an, nx, e;
		longint unsigned dt, dd;
		w.chg = 0; w.dis = 0; w.emp = 0; w.full = 0; w.corr = 0;
		if (o == bse_pkg::OP_REINIT) begin
			reload();
		end else begin
			nt = longint'(c) - longint'(d);
			an = nt < 0 ? -nt : nt;
			dt = 0;
			if (tick_seen && tick > prev_tick)
				dt = tick - prev_tick;
			prev_tick = tick;
			tick_seen = 1;
			if (dt > 0) begin
				nx = longint'(charge_left) + (nt * longint'(dt)) / 100;
				if (nx < 0) begin
					nx = 0; cnt_emp++; w.emp = 1;
				end
				if (nx > longint'(capacity)) begin
					nx = capacity; cnt_full++; w.full = 1;
				end
				charge_left = nx[21:0];
			end
			if (capacity == 0) begin
				level = 0;
			end else begin
				e = (longint'(charge_left) * 1000) / longint'(capacity);
				level = e > 1000 ? 10'd1000 : e[9:0];
			end
			if (nt > 0)
				w.chg = 1;
			else if (nt < 0)
				w.dis = 1;
			if (an <= idle_limit) begin
				if (idle_run != 8'd255)
					idle_run++;
			end else begin
				idle_run = 0;
			end
			if (ocv <= 1000 && idle_run >= idle_needed && ocv != level) begin
				if (ocv > level) begin
					dd = ocv - level;
					level = level + (step_limit < dd ? step_limit : dd);
				end else begin
					dd = level - ocv;
					level = level - (step_limit < dd ? step_limit : dd);
				end
				charge_left = charge_of(level);
				cnt_corr++;
				w.corr = 1;
			end
		end
		w.est = level;
		w.ocv = ocv;
		w.err = {7'd0, level} - {1'b0, ocv};
		w.n_emp = cnt_emp;
		w.n_full = cnt_full;
		w.n_corr = cnt_corr;
		pending.push_back(w);
	endfunction

	function void check_field(string n, longint unsigned x, longint unsigned a);
		if (x != a) begin
			$error("%s expected %0d got %0d", n, x, a);
			errors++;
		end
	endfunction

	function void check_result(soc_word_t a);
		soc_word_t x;
		if (pending.size() == 0) begin
			$error("unexpected word");
			errors++;
			return;
		end
		x = pending.pop_front();
		check_field("est_soc_out", x.est, a.est);
		check_field("ocv_soc_out", x.ocv, a.ocv);
		check_field("soc_error", x.err, a.err);
		check_field("flag_charge", x.chg, a.chg);
		check_field("flag_discharge", x.dis, a.dis);
		check_field("flag_clamped_empty", x.emp, a.emp);
		check_field("flag_clamped_full", x.full, a.full);
		check_field("flag_ocv_corrected", x.corr, a.corr);
		check_field("empty_clamps_total", x.n_emp, a.n_emp);
		check_field("full_clamps_total", x.n_full, a.n_full);
		check_field("corrections_total", x.n_corr, a.n_corr);
	endfunction
endclass

module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [21:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        op = 0;
	logic [31:0] tick_time_ms = '0;
	logic [14:0] charge_ma = '0;
	logic [14:0] discharge_ma = '0;
	logic [15:0] ocv_soc = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [9:0]  est_soc_out;
	logic [15:0] ocv_soc_out;
	logic signed [16:0] soc_error;
	logic flag_charge, flag_discharge, flag_clamped_empty;
	logic flag_clamped_full, flag_ocv_corrected;
	logic [31:0] empty_clamps_total, full_clamps_total, corrections_total;

	soc_scoreboard sb = new();
	bit          quiet = 0;
	int          hold_off = 0;
	longint      cycles = 0;
	logic [31:0] clock_ms = 0;

	battery_soc_estimator_top dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("[battery_soc_estimator_top] ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts, a long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				out_stall <= 1;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1;
				n = $urandom_range(1, 8);
				repeat (n) @(posedge clk);
			end else begin
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		soc_word_t a;
		if (out_valid && !out_stall) begin
			a.est = est_soc_out; a.ocv = ocv_soc_out; a.err = soc_error;
			a.chg = flag_charge; a.dis = flag_discharge;
			a.emp = flag_clamped_empty; a.full = flag_clamped_full;
			a.corr = flag_ocv_corrected;
			a.n_emp = empty_clamps_total; a.n_full = full_clamps_total;
			a.n_corr = corrections_total;
			sb.check_result(a);
		end
	end

	task automatic send_word(logic o, logic [31:0] t, logic [14:0] c,
			logic [14:0] d, logic [15:0] v);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 8);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		op <= o; tick_time_ms <= t; charge_ma <= c;
		discharge_ma <= d; ocv_soc <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(o, t, c, d, v);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [21:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic sample_word(int mode);
		logic [14:0] c, d;
		logic [15:0] v;
		int k;
		k = $urandom_range(0, 9);
		clock_ms = clock_ms + (k == 0 ? 0 : $urandom_range(1, mode == 2 ? 5000 : 300));
		if (k == 1)
			clock_ms = $urandom;
		if (mode == 0 || $urandom_range(0, 2) == 0) begin
			c = 15'($urandom_range(0, 300));
			d = 15'($urandom_range(0, 300));
		end else begin
			c = 15'($urandom); d = 15'($urandom);
		end
		v = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1000));
		send_word($urandom_range(0, 40) == 0 ? bse_pkg::OP_REINIT : bse_pkg::OP_SAMPLE,
			clock_ms, c, d, v);
	endtask

	task automatic config_phase(int p);
		case (p % 5)
			0: begin
				write_reg(bse_pkg::REG_FULL_CAPACITY, 22'd4000000);
				write_reg(bse_pkg::REG_START_SOC, 22'd1000);
				write_reg(bse_pkg::REG_BLEND_STEP, 22'd1000);
				write_reg(bse_pkg::REG_IDLE_THRESHOLD, 22'd65535);
				write_reg(bse_pkg::REG_IDLE_DELAY, 22'd0);
			end
			1: begin
				write_reg(bse_pkg::REG_FULL_CAPACITY, 22'd1);
				write_reg(bse_pkg::REG_START_SOC, 22'd0);
				write_reg(bse_pkg::REG_BLEND_STEP, 22'd0);
				write_reg(bse_pkg::REG_IDLE_THRESHOLD, 22'd0);
				write_reg(bse_pkg::REG_IDLE_DELAY, 22'd255);
			end
			2: begin
				write_reg(bse_pkg::REG_FULL_CAPACITY, 22'($urandom_range(1000, 50000)));
				write_reg(bse_pkg::REG_START_SOC, 22'd1023);
				write_reg(bse_pkg::REG_BLEND_STEP, 22'($urandom_range(1, 50)));
				write_reg(bse_pkg::REG_IDLE_THRESHOLD, 22'($urandom_range(50, 400)));
				write_reg(bse_pkg::REG_IDLE_DELAY, 22'($urandom_range(0, 4)));
			end
			3: begin
				write_reg(bse_pkg::REG_FULL_CAPACITY, 22'd0);
				write_reg(bse_pkg::REG_START_SOC, 22'($urandom_range(0, 1000)));
			end
			default: begin
				write_reg(bse_pkg::REG_FULL_CAPACITY, 22'h3FFFFF);
				write_reg(bse_pkg::REG_START_SOC, 22'd500);
				write_reg(bse_pkg::REG_BLEND_STEP, 22'd15);
				write_reg(bse_pkg::REG_IDLE_THRESHOLD, 22'd150);
				write_reg(bse_pkg::REG_IDLE_DELAY, 22'd3);
			end
		endcase
		send_word(bse_pkg::OP_REINIT, 32'd0, 15'd0, 15'd0, 16'd500);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, reinit, first sample, stalled clock, invalid ocv
		send_word(bse_pkg::OP_SAMPLE, 32'd1000, 15'h7FFF, 15'd0, 16'd1000);
		send_word(bse_pkg::OP_SAMPLE, 32'd1000, 15'd0, 15'h7FFF, 16'hFFFF);
		send_word(bse_pkg::OP_SAMPLE, 32'd500, 15'd0, 15'd0, 16'd0);
		send_word(bse_pkg::OP_SAMPLE, 32'hFFFFFFFF, 15'h7FFF, 15'd0, 16'd1001);
		send_word(bse_pkg::OP_SAMPLE, 32'd0, 15'd0, 15'd0, 16'd0);
		send_word(bse_pkg::OP_SAMPLE, 32'hFFFFFFFF, 15'd0, 15'h7FFF, 16'd0);
		send_word(bse_pkg::OP_REINIT, 32'hFFFFFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
		for (int i = 0; i < 8; i++)
			send_word(bse_pkg::OP_SAMPLE, 32'd100 * i, 15'd100, 15'd90, 16'(i * 120));
		send_word(bse_pkg::OP_SAMPLE, 32'd2000, 15'h5555, 15'h2AAA, 16'hAAAA);
		send_word(bse_pkg::OP_SAMPLE, 32'd3000, 15'h2AAA, 15'h5555, 16'h5555);
		drain();
		// capacity lowered under the stored charge
		write_reg(bse_pkg::REG_FULL_CAPACITY, 22'd1000);
		send_word(bse_pkg::OP_SAMPLE, 32'd3000, 15'd0, 15'd0, 16'd2000);
		drain();
		for (int p = 0; p < 6; p++) begin
			config_phase(p);
			for (int i = 0; i < 190; i++) begin
				if (i == 60)
					hold_off = 400;
				sample_word(i % 3);
			end
			if (p == 2) begin
				in_valid <= 0;
				while (sb.pending.size() != 0)
					@(posedge clk);
			end
			drain();
		end
		quiet = 1;
		config_phase(4);
		for (int i = 0; i < 80; i++)
			sample_word(0);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[battery_soc_estimator_top] OK");
		else
			$display("[battery_soc_estimator_top] ERROR");
		$finish;
	end
endmodule

### battery_soc_estimator_top.f
rtl/core/bse_pkg.sv
rtl/core/bse_div.sv
rtl/core/battery_soc_estimator_top.sv
sim/testbench.sv
